### hw/rtl/ffdc_pkg.sv
`timescale 1ns / 1ps
package ffdc_pkg;

  localparam int unsigned DATA_W = 112;

  // frame byte positions
  localparam logic [7:0] POS_TYPE    = 8'd0;
  localparam logic [7:0] POS_LEN_HI  = 8'd1;
  localparam logic [7:0] POS_LEN_LO  = 8'd2;
  localparam logic [7:0] POS_PAYLOAD = 8'd3;
  localparam logic [7:0] POS_SUM_END = 8'd250;
  localparam logic [7:0] POS_CK_LO   = 8'd251;
  localparam logic [7:0] POS_STAMP   = 8'd252;
  localparam logic [7:0] POS_LAST    = 8'd255;

  localparam logic [15:0] MAX_LEN = 16'd247;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_LEN_BAD  = 2'd1;
  localparam logic [1:0] STATUS_CK_BAD   = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [31:0] stamp;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;
    logic [1:0]  status;
  } res_t;

endpackage

### hw/rtl/ffdc_parse.sv
`timescale 1ns / 1ps
module ffdc_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    byte_in,
  output logic          res_valid,
  output ffdc_pkg::res_t res
);
  import ffdc_pkg::*;

  logic [7:0]  pos_r,      pos_nxt;
  logic [15:0] sum_r,      sum_nxt;
  logic [7:0]  type_r,     type_nxt;
  logic [15:0] len_r,      len_nxt;
  logic [15:0] ck_r,       ck_nxt;
  logic [31:0] stamp_r,    stamp_nxt;

  logic [15:0] sum_base;
  logic [15:0] sum_new;
  logic [7:0]  idx;
  logic        len_ok;
  logic        is_payload;
  logic [15:0] computed;

  always_comb begin
    sum_base   = (pos_r == POS_TYPE) ? 16'd0 : sum_r;
    sum_new    = (pos_r < POS_SUM_END) ? (sum_base + {8'd0, byte_in}) : sum_base;
    idx        = pos_r - POS_PAYLOAD;
    len_ok     = (len_r <= MAX_LEN);
    // the byte sum of 250 bytes cannot carry out of 16 bits, so the fold is a no-op
    computed   = ~sum_new;
    is_payload = (pos_r >= POS_PAYLOAD) && (pos_r < POS_SUM_END) && len_ok
                 && ({8'd0, idx} < len_r);

    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    ck_nxt    = ck_r;
    stamp_nxt = stamp_r;
    if (step) begin
      pos_nxt = pos_r + 8'd1;
      sum_nxt = sum_new;
      if (pos_r == POS_TYPE)   type_nxt = byte_in;
      if (pos_r == POS_LEN_HI) len_nxt  = {byte_in, 8'd0};
      if (pos_r == POS_LEN_LO) len_nxt  = {len_r[15:8], byte_in};
      if (pos_r == POS_SUM_END) ck_nxt  = {byte_in, 8'd0};
      if (pos_r == POS_CK_LO)  ck_nxt   = {ck_r[15:8], byte_in};
      if (pos_r >= POS_STAMP)  stamp_nxt = {stamp_r[23:0], byte_in};
    end

    res = '0;
    res_valid = 1'b0;
    if (pos_r == POS_LAST) begin
      res_valid          = step;
      res.kind           = KIND_SUMMARY;
      res.frame_type     = type_r;
      res.payload_length = len_r;
      res.stamp          = {stamp_r[23:0], byte_in};
      res.received_sum   = ck_r;
      res.computed_sum   = computed;
      priority if (!len_ok) begin
        res.status = STATUS_LEN_BAD;
      end else if (computed != ck_r) begin
        res.status = STATUS_CK_BAD;
      end else begin
        res.status = STATUS_OK;
      end
    end else if (is_payload) begin
      res_valid         = step;
      res.kind          = KIND_PAYLOAD;
      res.payload_byte  = byte_in;
      res.payload_index = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      type_r  <= '0;
      len_r   <= '0;
      ck_r    <= '0;
      stamp_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      ck_r    <= ck_nxt;
      stamp_r <= stamp_nxt;
    end
  end

`ifndef SYNTH
  a_summary_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && pos_r == POS_LAST) |-> (res_valid && res.kind == KIND_SUMMARY))
    else $error("no summary on last frame byte");

  a_payload_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_PAYLOAD) |-> (len_r <= MAX_LEN))
    else $error("payload passed with oversize length");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (pos_r == 8'($past(pos_r) + 8'd1)))
    else $error("byte position did not advance");
`endif

endmodule

### hw/rtl/fixed_frame_deframe_check.sv
`timescale 1ns / 1ps
// A byte waits in the input register; its result (if any) is registered into out_*.
// Throughput: one byte per cycle; the input register drains whenever the
// output register is empty or being taken, so a stalled output stalls the input.
// Reset: rst_n is synchronous, active low; clears frame position, sums and valids,
// so the first byte after reset is byte 0 of a frame.
module fixed_frame_deframe_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_type,
  // [39:24] payload_length, [71:40] stamp, [87:72] received_sum,
  // [103:88] computed_sum, [105:104] status, [111:106] zero
  output logic [ffdc_pkg::DATA_W-1:0] out_tdata,
  output logic                        out_tuser   // [0] kind
);
  import ffdc_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic       out_kind_r;

  logic drain_ok;
  logic s1_go;
  logic in_go;
  logic res_valid;
  res_t res;

  assign drain_ok  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && drain_ok;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_go     = in_tvalid && in_tready;

  ffdc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .byte_in   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt = in_go || (s1_valid_r && !s1_go);
    if (s1_go && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load on transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (in_go) s1_byte_r <= in_tdata;
    if (s1_go && res_valid) begin
      out_kind_r <= res.kind;
      out_data_r <= {6'd0, res.status, res.computed_sum, res.received_sum, res.stamp,
                     res.payload_length, res.frame_type, res.payload_index,
                     res.payload_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !drain_ok) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("input stage dropped a stalled byte");

  a_s1_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && s1_valid_r) |-> s1_go)
    else $error("input stage overwritten before it drained");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res_valid) |=> out_valid_r)
    else $error("result lost on load");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ffdc_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_FRAMES = 1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // [7:0] in_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_type,
  // [39:24] payload_length, [71:40] stamp, [87:72] received_sum,
  // [103:88] computed_sum, [105:104] status, [111:106] zero
  logic [DATA_W-1:0]   out_tdata;
  logic                out_tuser;       // [0] kind

  fixed_frame_deframe_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  logic [7:0] pending_bytes[$];
  res_t       frame_results_due[$];
  int         total_bytes = 0;
  int         bytes_accepted = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  // parser state mirrored from the byte stream
  logic [7:0]  frame_pos = '0;
  logic [15:0] byte_sum = '0;
  logic [7:0]  cur_type = '0;
  logic [15:0] cur_length = '0;
  logic [15:0] cur_checksum = '0;
  logic [31:0] cur_stamp = '0;

  task automatic parse_frame_byte(input logic [7:0] b);
    res_t        r;
    logic [7:0]  idx;
    logic [15:0] computed;
    r = '0;
    if (frame_pos == POS_TYPE) byte_sum = '0;
    if (frame_pos < POS_SUM_END) byte_sum = byte_sum + 16'(b);
    if (frame_pos == POS_TYPE) begin
      cur_type = b;
    end else if (frame_pos == POS_LEN_HI) begin
      cur_length = {b, 8'h00};
    end else if (frame_pos == POS_LEN_LO) begin
      cur_length[7:0] = b;
    end else if (frame_pos < POS_SUM_END) begin
      idx = frame_pos - POS_PAYLOAD;
      if (cur_length <= MAX_LEN && 16'(idx) < cur_length) begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = idx;
        frame_results_due.push_back(r);
      end
    end else if (frame_pos == POS_SUM_END) begin
      cur_checksum = {b, 8'h00};
    end else if (frame_pos == POS_CK_LO) begin
      cur_checksum[7:0] = b;
    end else if (frame_pos < POS_LAST) begin
      cur_stamp = {cur_stamp[23:0], b};
    end else begin
      // 250 bytes never carry out of 16 bits, so the fold is a no-op
      computed = ~byte_sum;
      cur_stamp = {cur_stamp[23:0], b};
      r.kind = KIND_SUMMARY;
      r.frame_type = cur_type;
      r.payload_length = cur_length;
      r.stamp = cur_stamp;
      r.received_sum = cur_checksum;
      r.computed_sum = computed;
      if (cur_length > MAX_LEN) r.status = STATUS_LEN_BAD;
      else if (computed != cur_checksum) r.status = STATUS_CK_BAD;
      else r.status = STATUS_OK;
      frame_results_due.push_back(r);
    end
    frame_pos = frame_pos + 8'd1;
  endtask

  // fill < 0 gives random filler bytes between header and checksum
  task automatic queue_frame(input logic [7:0] ftype, input logic [15:0] flen,
                             input int fill, input bit ck_good,
                             input logic [31:0] fstamp);
    logic [7:0]  frame_bytes [256];
    logic [15:0] sum;
    logic [15:0] ck;
    sum = '0;
    frame_bytes[0] = ftype;
    frame_bytes[1] = flen[15:8];
    frame_bytes[2] = flen[7:0];
    for (int i = 3; i < 250; i++)
      frame_bytes[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    for (int i = 0; i < 250; i++) sum = sum + 16'(frame_bytes[i]);
    ck = ~sum;
    if (!ck_good) ck = ck ^ 16'($urandom_range(65535, 1));
    frame_bytes[250] = ck[15:8];
    frame_bytes[251] = ck[7:0];
    frame_bytes[252] = fstamp[31:24];
    frame_bytes[253] = fstamp[23:16];
    frame_bytes[254] = fstamp[15:8];
    frame_bytes[255] = fstamp[7:0];
    for (int i = 0; i < 256; i++) pending_bytes.push_back(frame_bytes[i]);
  endtask

  function automatic int traffic_phase();
    int p;
    p = (total_bytes == 0) ? 0 : (bytes_accepted * 4) / total_bytes;
    return (p > 3) ? 3 : p;
  endfunction

  function automatic int sender_idle_pct();
    case (traffic_phase())
      1: return 52;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (traffic_phase())
      2: return 52;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_frame_byte(in_tdata);
        bytes_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_tdata <= pending_bytes.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_results_due.size() == 0) begin
          $error("unexpected result transaction: kind %0d data 0x%0h", out_tuser, out_tdata);
          mismatches++;
        end else begin
          exp_res = frame_results_due.pop_front();
          check_field("kind", 32'(exp_res.kind), 32'(out_tuser));
          check_field("payload_byte", 32'(exp_res.payload_byte), 32'(out_tdata[7:0]));
          check_field("payload_index", 32'(exp_res.payload_index), 32'(out_tdata[15:8]));
          check_field("frame_type", 32'(exp_res.frame_type), 32'(out_tdata[23:16]));
          check_field("payload_length", 32'(exp_res.payload_length),
                      32'(out_tdata[39:24]));
          check_field("stamp", exp_res.stamp, out_tdata[71:40]);
          check_field("received_sum", 32'(exp_res.received_sum), 32'(out_tdata[87:72]));
          check_field("computed_sum", 32'(exp_res.computed_sum), 32'(out_tdata[103:88]));
          check_field("status", 32'(exp_res.status), 32'(out_tdata[105:104]));
          check_field("pad", 32'h0, 32'(out_tdata[111:106]));
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int          r;
    logic [15:0] len;
    // empty payload, all-zero type, length, filler and stamp
    queue_frame(8'h00, 16'd0, 8'h00, 1'b1, 32'h0000_0000);
    // longest payload, all-ones type, filler and stamp
    queue_frame(8'hFF, 16'd247, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    // largest possible sum; oversize length wins over a bad checksum
    queue_frame(8'hFF, 16'hFFFF, 8'hFF, 1'b0, $urandom);
    // one past the length limit
    queue_frame(8'h5A, 16'd248, -1, 1'b1, 32'h0123_4567);
    // single payload byte with a bad checksum
    queue_frame(8'hA5, 16'd1, -1, 1'b0, 32'h89AB_CDEF);
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      r = $urandom_range(99);
      if (r < 10) len = 16'd0;
      else if (r < 20) len = MAX_LEN;
      else if (r < 28) len = 16'($urandom_range(65535, 248));
      else if (r < 33) len = 16'd248;
      else len = 16'($urandom_range(246, 1));
      queue_frame(8'($urandom), len, -1, ($urandom_range(99) < 75), $urandom);
    end
    total_bytes = pending_bytes.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted < total_bytes) @(posedge clk);
    while (frame_results_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
